// File: rtl/core/abrd_pkg.sv
// abrd_pkg: shared constants for the alignment bad region detector.
// No dependencies; imported by every module of the block.

package abrd_pkg;

   localparam int POS_BITS_DEF   = 16;
   localparam int EVQ_DEPTH_DEF  = 4;
   localparam int CNT_BITS       = 16;
   localparam int RUN_BITS       = 7;
   localparam int BLK_BITS       = 5;
   localparam int MM_BITS        = 5;
   localparam logic [MM_BITS-1:0] MIN_MATCHES_RST = 5'd12;

endpackage

// File: rtl/core/abrd_front.sv
// abrd_front: column classifier; tracks match run, region state and
// mismatch count, builds up to two events per accepted item.
// Depends on abrd_pkg.

module abrd_front #(
   parameter int POS_BITS = abrd_pkg::POS_BITS_DEF,
   localparam int EV_BITS = 2 * POS_BITS + abrd_pkg::CNT_BITS + 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic                        csr_we,
   input  logic [abrd_pkg::MM_BITS-1:0] csr_wdata,
   input  logic [1:0]                  base_a,
   input  logic [1:0]                  base_b,
   input  logic [POS_BITS-1:0]         col_pos_a,
   input  logic [POS_BITS-1:0]         col_pos_b,
   input  logic                        block_first,
   input  logic                        block_last,
   input  logic                        alignment_first_block,
   input  logic                        alignment_last_block,
   output logic [1:0]                  ev_cnt,
   output logic [EV_BITS-1:0]          ev0,
   output logic [EV_BITS-1:0]          ev1
);
   import abrd_pkg::*;

   localparam logic [RUN_BITS-1:0] RUN_MAX = '1;
   localparam logic [BLK_BITS-1:0] BLK_MAX = '1;
   localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   logic [MM_BITS-1:0]  min_matches_ff;
   logic [RUN_BITS-1:0] match_run_ff, match_run_in;
   logic                region_open_ff, region_open_in;
   logic [CNT_BITS-1:0] region_mm_ff, region_mm_in;
   logic [BLK_BITS-1:0] block_cols_ff, block_cols_in;
   logic [POS_BITS-1:0] fbs_a_ff, fbs_a_in;
   logic [POS_BITS-1:0] fbs_b_ff, fbs_b_in;

   logic                new_aln, mismatch;
   logic [POS_BITS-1:0] h_p, bo_a, bo_b;
   logic [POS_BITS:0]   near_lim;
   logic                near;
   logic [RUN_BITS-1:0] run0, run1;
   logic                open0, open1, open2;
   logic [CNT_BITS-1:0] mm0, mm1, mm2;
   logic                va, vb, a_end, b_end;
   logic [POS_BITS-1:0] a_pa, a_pb, b_pa, b_pb;
   logic [CNT_BITS-1:0] a_cnt, b_cnt;
   logic [BLK_BITS-1:0] k;
   logic [POS_BITS:0]   pa1, pb1, sa_w, sb_w;

   always_comb begin
      new_aln  = block_first && alignment_first_block;
      mismatch = (base_a != base_b);
      h_p      = {{(POS_BITS-MM_BITS){1'b0}}, min_matches_ff};

      fbs_a_in = new_aln ? col_pos_a : fbs_a_ff;
      fbs_b_in = new_aln ? col_pos_b : fbs_b_ff;

      if (block_first) begin
         block_cols_in = BLK_BITS'(1);
      end else if (block_cols_ff < BLK_MAX) begin
         block_cols_in = block_cols_ff + BLK_BITS'(1);
      end else begin
         block_cols_in = block_cols_ff;
      end
      run0  = block_first ? '0 : match_run_ff;
      open0 = new_aln ? 1'b0 : region_open_ff;
      mm0   = new_aln ? '0 : region_mm_ff;

      if (mismatch) begin
         run1 = '0;
         mm1  = (mm0 < CNT_MAX) ? mm0 + CNT_BITS'(1) : mm0;
      end else begin
         run1 = (run0 < RUN_MAX) ? run0 + RUN_BITS'(1) : run0;
         mm1  = mm0;
      end

      bo_a     = (col_pos_a >= h_p) ? col_pos_a - h_p : '0;
      bo_b     = (col_pos_b >= h_p) ? col_pos_b - h_p : '0;
      near_lim = {1'b0, fbs_a_in} + {1'b0, h_p};
      near     = alignment_first_block && ({1'b0, col_pos_a} < near_lim);

      // mismatch start or match-run end; never both in one column
      va    = 1'b0;
      a_end = 1'b0;
      a_pa  = bo_a;
      a_pb  = bo_b;
      a_cnt = '0;
      open1 = open0;
      open2 = open0;
      mm2   = mm1;
      match_run_in = run1;
      if (!open0 && mismatch) begin
         va    = 1'b1;
         open1 = 1'b1;
         open2 = 1'b1;
         if (near) begin
            a_pa = fbs_a_in;
            a_pb = fbs_b_in;
         end
      end
      if (open1 && !mismatch && (run1 == {1'b0, min_matches_ff, 1'b0})) begin
         va    = 1'b1;
         a_end = 1'b1;
         a_cnt = mm1;
         open2 = 1'b0;
         mm2   = '0;
         match_run_in = run1 - {{(RUN_BITS-MM_BITS){1'b0}}, min_matches_ff};
      end

      // block boundary event
      k    = (block_cols_in < min_matches_ff) ? block_cols_in : min_matches_ff;
      pa1  = {1'b0, col_pos_a} + (POS_BITS+1)'(1);
      pb1  = {1'b0, col_pos_b} + (POS_BITS+1)'(1);
      sa_w = (pa1 >= {{(POS_BITS+1-BLK_BITS){1'b0}}, k}) ?
             pa1 - {{(POS_BITS+1-BLK_BITS){1'b0}}, k} : '0;
      sb_w = (pb1 >= {{(POS_BITS+1-BLK_BITS){1'b0}}, k}) ?
             pb1 - {{(POS_BITS+1-BLK_BITS){1'b0}}, k} : '0;
      vb    = 1'b0;
      b_end = 1'b0;
      b_pa  = sa_w[POS_BITS] ? POS_MAX : sa_w[POS_BITS-1:0];
      b_pb  = sb_w[POS_BITS] ? POS_MAX : sb_w[POS_BITS-1:0];
      b_cnt = '0;
      region_open_in = open2;
      region_mm_in   = mm2;
      if (block_last) begin
         if (!alignment_last_block) begin
            if (!open2) begin
               vb = 1'b1;
               region_open_in = 1'b1;
            end
         end else if (open2) begin
            vb    = 1'b1;
            b_end = 1'b1;
            b_pa  = col_pos_a;
            b_pb  = col_pos_b;
            b_cnt = mm2;
            region_open_in = 1'b0;
            region_mm_in   = '0;
         end
      end

      ev_cnt = {1'b0, va} + {1'b0, vb};
      ev0 = va ? {a_end, a_pa, a_pb, a_cnt, !vb} : {b_end, b_pa, b_pb, b_cnt, 1'b1};
      ev1 = {b_end, b_pa, b_pb, b_cnt, 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_matches_ff <= MIN_MATCHES_RST;
         match_run_ff   <= '0;
         region_open_ff <= 1'b0;
         region_mm_ff   <= '0;
         block_cols_ff  <= '0;
         fbs_a_ff       <= '0;
         fbs_b_ff       <= '0;
      end else begin
         if (csr_we) begin
            min_matches_ff <= csr_wdata;
         end
         if (accept) begin
            match_run_ff   <= match_run_in;
            region_open_ff <= region_open_in;
            region_mm_ff   <= region_mm_in;
            block_cols_ff  <= block_cols_in;
            fbs_a_ff       <= fbs_a_in;
            fbs_b_ff       <= fbs_b_in;
         end
      end
   end

endmodule

// File: rtl/core/abrd_evq.sv
// abrd_evq: event queue between classifier and result port; takes up to
// two events per cycle, hands out one. Depends on abrd_pkg.

module abrd_evq #(
   parameter int DEPTH = abrd_pkg::EVQ_DEPTH_DEF,
   parameter int WIDTH = 50
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       wr_cnt,
   input  logic [WIDTH-1:0] wr_data0,
   input  logic [WIDTH-1:0] wr_data1,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             full,
   output logic             empty
);
   import abrd_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_LVL = CW'(DEPTH - 2);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wp_ff, wp_in, wp1, rp_ff, rp_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_rd;

   function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
      return (p == LAST_IDX) ? '0 : p + AW'(1);
   endfunction

   always_comb begin
      empty    = (count_ff == '0);
      full     = (count_ff > FULL_LVL);
      do_rd    = rd_en && !empty;
      rd_data  = mem_ff[rp_ff];
      wp1      = nxt(wp_ff);
      wp_in    = (wr_cnt == 2'd2) ? nxt(wp1) : ((wr_cnt == 2'd1) ? wp1 : wp_ff);
      rp_in    = do_rd ? nxt(rp_ff) : rp_ff;
      count_in = count_ff + {{(CW-2){1'b0}}, wr_cnt} - {{(CW-1){1'b0}}, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_cnt != 2'd0) begin
         mem_ff[wp_ff] <= wr_data0;
      end
      if (wr_cnt == 2'd2) begin
         mem_ff[wp1] <= wr_data1;
      end
   end

endmodule

// File: rtl/core/alignment_bad_region_detector.sv
// alignment_bad_region_detector: top level; classifier front plus event queue.
// Depends on abrd_pkg, abrd_front, abrd_evq.
//
// Input side is a queue write port: an item (one alignment column) is taken
// on a clock edge with push high and full low. Result side is a queue read
// port: the oldest event sits on rsp_* while empty is low and leaves on an
// edge with pop high. One column makes zero, one or two events, in order;
// rsp_last_of_run marks the final event of a column.
// An event is visible in the cycle after its column is taken.
// Throughput: one column per cycle while the reader pops every cycle and
// columns make at most one event; the result port moves one event a cycle,
// so two-event columns build up the queue. An EVQ_DEPTH event queue
// decouples the sides; full rises when fewer than two slots are free.
// csr_we/csr_wdata write min_matches; write it only while the block is idle.
// Reset (synchronous) clears all tracking state, empties the queue and sets
// min_matches to 12. A stalled reader backs up the queue, then raises full.

module alignment_bad_region_detector #(
   parameter int POS_BITS  = abrd_pkg::POS_BITS_DEF,
   parameter int EVQ_DEPTH = abrd_pkg::EVQ_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [1:0]                   req_base_a,
   input  logic [1:0]                   req_base_b,
   input  logic [POS_BITS-1:0]          req_col_pos_a,
   input  logic [POS_BITS-1:0]          req_col_pos_b,
   input  logic                         req_block_first,
   input  logic                         req_block_last,
   input  logic                         req_alignment_first_block,
   input  logic                         req_alignment_last_block,
   output logic                         empty,
   input  logic                         pop,
   output logic                         rsp_is_end,
   output logic [POS_BITS-1:0]          rsp_event_pos_a,
   output logic [POS_BITS-1:0]          rsp_event_pos_b,
   output logic [abrd_pkg::CNT_BITS-1:0] rsp_mismatch_count,
   output logic                         rsp_last_of_run,
   input  logic                         csr_we,
   input  logic [abrd_pkg::MM_BITS-1:0]  csr_wdata
);
   import abrd_pkg::*;

   localparam int EV_BITS = 2 * POS_BITS + CNT_BITS + 2;

   logic               accept;
   logic [1:0]         ev_cnt, wr_cnt;
   logic [EV_BITS-1:0] ev0, ev1, rd_data;

   assign accept = push && !full;
   assign wr_cnt = accept ? ev_cnt : 2'd0;

   abrd_front #(.POS_BITS(POS_BITS)) u_front (
      .clock                 (clock),
      .reset                 (reset),
      .accept                (accept),
      .csr_we                (csr_we),
      .csr_wdata             (csr_wdata),
      .base_a                (req_base_a),
      .base_b                (req_base_b),
      .col_pos_a             (req_col_pos_a),
      .col_pos_b             (req_col_pos_b),
      .block_first           (req_block_first),
      .block_last            (req_block_last),
      .alignment_first_block (req_alignment_first_block),
      .alignment_last_block  (req_alignment_last_block),
      .ev_cnt                (ev_cnt),
      .ev0                   (ev0),
      .ev1                   (ev1)
   );

   abrd_evq #(.DEPTH(EVQ_DEPTH), .WIDTH(EV_BITS)) u_evq (
      .clock    (clock),
      .reset    (reset),
      .wr_cnt   (wr_cnt),
      .wr_data0 (ev0),
      .wr_data1 (ev1),
      .rd_en    (pop),
      .rd_data  (rd_data),
      .full     (full),
      .empty    (empty)
   );

   assign rsp_is_end         = rd_data[EV_BITS-1];
   assign rsp_event_pos_a    = rd_data[EV_BITS-2 -: POS_BITS];
   assign rsp_event_pos_b    = rd_data[EV_BITS-2-POS_BITS -: POS_BITS];
   assign rsp_mismatch_count = rd_data[CNT_BITS:1];
   assign rsp_last_of_run    = rd_data[0];

   a_ev_cnt_range: assert property (@(posedge clock) disable iff (reset)
      ev_cnt != 2'd3)
      else $error("more than two events from one item");

   a_pair_kinds: assert property (@(posedge clock) disable iff (reset)
      (ev_cnt == 2'd2) |-> (ev0[EV_BITS-1] != ev1[EV_BITS-1]) && !ev0[0] && ev1[0])
      else $error("event pair of one item malformed");

   a_event_visible: assert property (@(posedge clock) disable iff (reset)
      (accept && ev_cnt != 2'd0) |=> !empty)
      else $error("event of accepted item not visible");

   a_quiet_no_push: assert property (@(posedge clock) disable iff (reset)
      (empty && !accept) |=> empty)
      else $error("result appeared without an accepted item");

endmodule
